@@ src/tsq_pkg.sv @@
package tsq_pkg;

   localparam int STACK_DEPTH = 128;
   localparam int PTR_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = PTR_W + 1;
   localparam int WORD_W      = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic       FUNC_DEQUEUE = 1'b1;
   localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;
   localparam logic signed [WORD_W-1:0] ZERO_WORD  = '0;

   typedef enum logic [0:0] {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_DEQUEUED = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef struct packed {
      op_type                    op;
      logic signed [WORD_W-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] in_cnt;
      logic [CNT_W-1:0] out_cnt;
   } stack_stat_type;

endpackage

@@ src/tsq_ram.sv @@
module tsq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/tsq_front.sv @@
module tsq_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_func,
   input  logic signed [tsq_pkg::WORD_W-1:0] req_value,
   output logic                          cmd_valid,
   input  logic                          cmd_ready,
   output tsq_pkg::cmd_type              cmd
);

   tsq_pkg::cmd_type             entry_ff [tsq_pkg::QUEUE_DEPTH];
   logic [tsq_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [tsq_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [tsq_pkg::QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                         push, pop;
   tsq_pkg::cmd_type             new_cmd;

   // decode the request into a command
   always_comb begin
      new_cmd.op    = (req_func == tsq_pkg::FUNC_DEQUEUE) ? tsq_pkg::OP_DEQUEUE
                                                          : tsq_pkg::OP_ENQUEUE;
      new_cmd.value = req_value;
   end

   assign busy      = (cnt_ff == tsq_pkg::QCNT_W'(tsq_pkg::QUEUE_DEPTH));
   assign push      = start && !busy;
   assign cmd_valid = (cnt_ff != '0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tsq_pkg::QPTR_W'(tsq_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == tsq_pkg::QPTR_W'(tsq_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

@@ src/tsq_back.sv @@
module tsq_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   output logic                              cmd_ready,
   input  tsq_pkg::cmd_type                  cmd,
   output logic                              rsp_strobe,
   output logic signed [tsq_pkg::WORD_W-1:0] rsp_data_out,
   output logic [1:0]                        rsp_status,
   output tsq_pkg::stack_stat_type           stat
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_MOVE = 3'b010,
      S_LOAD = 3'b100
   } state_type;

   state_type                         state_ff, state_in;
   logic [tsq_pkg::CNT_W-1:0]         in_cnt_ff, in_cnt_in;
   logic [tsq_pkg::CNT_W-1:0]         out_cnt_ff, out_cnt_in;
   logic                              mv_pend_ff, mv_pend_in;
   logic                              strobe_ff, strobe_in;
   logic signed [tsq_pkg::WORD_W-1:0] data_ff, data_in;
   tsq_pkg::status_type               status_ff, status_in;

   logic [tsq_pkg::CNT_W-1:0]         in_top, out_top;
   logic                              in_full;

   logic                              in_wr_en, in_rd_en;
   logic [tsq_pkg::WORD_W-1:0]        in_rd_data;
   logic                              out_wr_en, out_rd_en;
   logic [tsq_pkg::WORD_W-1:0]        out_rd_data;

   assign in_top    = in_cnt_ff - 1'b1;
   assign out_top   = out_cnt_ff - 1'b1;
   assign in_full   = (in_cnt_ff == tsq_pkg::CNT_W'(tsq_pkg::STACK_DEPTH));
   assign cmd_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      in_cnt_in  = in_cnt_ff;
      out_cnt_in = out_cnt_ff;
      mv_pend_in = 1'b0;
      strobe_in  = 1'b0;
      data_in    = data_ff;
      status_in  = status_ff;
      in_wr_en   = 1'b0;
      in_rd_en   = 1'b0;
      out_wr_en  = 1'b0;
      out_rd_en  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               priority if (cmd.op == tsq_pkg::OP_ENQUEUE) begin
                  strobe_in = 1'b1;
                  data_in   = tsq_pkg::ZERO_WORD;
                  if (in_full) begin
                     status_in = tsq_pkg::ST_OVERFLOW;
                  end else begin
                     status_in = tsq_pkg::ST_ENQUEUED;
                     in_wr_en  = 1'b1;
                     in_cnt_in = in_cnt_ff + 1'b1;
                  end
               end else if (out_cnt_ff != '0) begin
                  out_rd_en  = 1'b1;
                  out_cnt_in = out_top;
                  state_in   = S_LOAD;
               end else if (in_cnt_ff != '0) begin
                  state_in = S_MOVE;
               end else begin
                  strobe_in = 1'b1;
                  data_in   = tsq_pkg::EMPTY_WORD;
                  status_in = tsq_pkg::ST_EMPTY;
               end
            end
         end
         S_MOVE: begin
            // read of inbound top overlaps write of the previous beat
            if (mv_pend_ff) begin
               out_wr_en  = 1'b1;
               out_cnt_in = out_cnt_ff + 1'b1;
            end
            priority if (in_cnt_ff != '0) begin
               in_rd_en   = 1'b1;
               in_cnt_in  = in_top;
               mv_pend_in = 1'b1;
            end else if (!mv_pend_ff) begin
               out_rd_en  = 1'b1;
               out_cnt_in = out_top;
               state_in   = S_LOAD;
            end else begin
               state_in = S_MOVE;
            end
         end
         S_LOAD: begin
            strobe_in = 1'b1;
            data_in   = out_rd_data;
            status_in = tsq_pkg::ST_DEQUEUED;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         in_cnt_ff  <= '0;
         out_cnt_ff <= '0;
         mv_pend_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         in_cnt_ff  <= in_cnt_in;
         out_cnt_ff <= out_cnt_in;
         mv_pend_ff <= mv_pend_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff   <= data_in;
      status_ff <= status_in;
   end

   tsq_ram #(
      .WIDTH (tsq_pkg::WORD_W),
      .DEPTH (tsq_pkg::STACK_DEPTH)
   ) u_inbound (
      .clock   (clock),
      .wr_en   (in_wr_en),
      .wr_addr (in_cnt_ff[tsq_pkg::PTR_W-1:0]),
      .wr_data (cmd.value),
      .rd_en   (in_rd_en),
      .rd_addr (in_top[tsq_pkg::PTR_W-1:0]),
      .rd_data (in_rd_data)
   );

   tsq_ram #(
      .WIDTH (tsq_pkg::WORD_W),
      .DEPTH (tsq_pkg::STACK_DEPTH)
   ) u_outbound (
      .clock   (clock),
      .wr_en   (out_wr_en),
      .wr_addr (out_cnt_ff[tsq_pkg::PTR_W-1:0]),
      .wr_data (in_rd_data),
      .rd_en   (out_rd_en),
      .rd_addr (out_top[tsq_pkg::PTR_W-1:0]),
      .rd_data (out_rd_data)
   );

   assign rsp_strobe   = strobe_ff;
   assign rsp_data_out = data_ff;
   assign rsp_status   = status_ff;
   assign stat.in_cnt  = in_cnt_ff;
   assign stat.out_cnt = out_cnt_ff;

endmodule

@@ src/two_stack_queue.sv @@
// enqueue, overflow and empty results pass the command queue and result register;
// dequeue from a filled outbound stack adds the outbound ram read and S_LOAD;
// a refilling dequeue adds S_MOVE (one entry per cycle through the stack rams)
// throughput: one request per cycle while the back end keeps up; busy rises when
// the 2-entry command queue is full; the receiver cannot stall results
// reset: synchronous, clears both stack counts and the command queue
module two_stack_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_func,
   input  logic signed [tsq_pkg::WORD_W-1:0] req_value,
   output logic                              rsp_strobe,
   output logic signed [tsq_pkg::WORD_W-1:0] rsp_data_out,
   output logic [1:0]                        rsp_status
);

   logic                    cmd_valid;
   logic                    cmd_ready;
   tsq_pkg::cmd_type        cmd;
   tsq_pkg::stack_stat_type stat;

   tsq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_func  (req_func),
      .req_value (req_value),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   tsq_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd_ready    (cmd_ready),
      .cmd          (cmd),
      .rsp_strobe   (rsp_strobe),
      .rsp_data_out (rsp_data_out),
      .rsp_status   (rsp_status),
      .stat         (stat)
   );

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      stat.in_cnt <= tsq_pkg::CNT_W'(tsq_pkg::STACK_DEPTH) &&
      stat.out_cnt <= tsq_pkg::CNT_W'(tsq_pkg::STACK_DEPTH))
      else $error("stack count out of range");

   a_empty_means_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == tsq_pkg::ST_EMPTY
      |-> stat.in_cnt == '0 && stat.out_cnt == '0)
      else $error("empty status with entries stored");

   a_enqueue_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == tsq_pkg::ST_ENQUEUED |-> stat.in_cnt != '0)
      else $error("enqueue reported without inbound entry");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == tsq_pkg::ST_OVERFLOW
      |-> stat.in_cnt == tsq_pkg::CNT_W'(tsq_pkg::STACK_DEPTH) && rsp_data_out == '0)
      else $error("overflow reported with inbound stack not full");
`endif

endmodule

@@ test/tsq_checker.sv @@
module tsq_checker
   import tsq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic                     req_func,
   input  logic signed [WORD_W-1:0] req_value,
   input  logic                     rsp_strobe,
   input  logic signed [WORD_W-1:0] rsp_data_out,
   input  logic [1:0]               rsp_status,
   output int                       fail_count,
   output int                       pending
);

   logic signed [WORD_W-1:0] inbound_words  [STACK_DEPTH];
   logic signed [WORD_W-1:0] outbound_words [STACK_DEPTH];
   int inbound_depth  = 0;
   int outbound_depth = 0;

   logic signed [WORD_W-1:0] expected_words [$];
   status_type               expected_codes [$];

   int mismatches = 0;
   int reported   = 0;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic void predict_queue_op(input op_type op,
                                            input logic signed [WORD_W-1:0] word);
      if (op == OP_ENQUEUE) begin
         if (inbound_depth >= STACK_DEPTH) begin
            expected_words.push_back(ZERO_WORD);
            expected_codes.push_back(ST_OVERFLOW);
         end else begin
            inbound_words[inbound_depth] = word;
            inbound_depth++;
            expected_words.push_back(ZERO_WORD);
            expected_codes.push_back(ST_ENQUEUED);
         end
      end else begin
         // refill reverses the inbound order
         if (outbound_depth == 0) begin
            while (inbound_depth > 0) begin
               inbound_depth--;
               outbound_words[outbound_depth] = inbound_words[inbound_depth];
               outbound_depth++;
            end
         end
         if (outbound_depth == 0) begin
            expected_words.push_back(EMPTY_WORD);
            expected_codes.push_back(ST_EMPTY);
         end else begin
            outbound_depth--;
            expected_words.push_back(outbound_words[outbound_depth]);
            expected_codes.push_back(ST_DEQUEUED);
         end
      end
   endfunction

   function automatic void check_result();
      logic signed [WORD_W-1:0] want_word;
      status_type               want_code;
      if (expected_words.size() == 0) begin
         mismatches++;
         if (reported < 10) begin
            reported++;
            $display("unexpected result beat: data %0d status %0d",
                     rsp_data_out, rsp_status);
         end
      end else begin
         want_word = expected_words.pop_front();
         want_code = expected_codes.pop_front();
         if (rsp_data_out !== want_word || rsp_status !== want_code) begin
            mismatches++;
            if (reported < 10) begin
               reported++;
               $display("mismatch: expected data %0d status %0d, got data %0d status %0d",
                        want_word, want_code, rsp_data_out, rsp_status);
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         inbound_depth  = 0;
         outbound_depth = 0;
         expected_words.delete();
         expected_codes.delete();
      end else begin
         if (rsp_strobe) begin
            check_result();
         end
         if (start && !busy) begin
            predict_queue_op(op_type'(req_func), req_value);
         end
      end
      pending    <= expected_words.size();
      fail_count <= mismatches;
   end

endmodule

@@ test/tb_top.sv @@
module tb_top;
   import tsq_pkg::*;

   localparam int ITEM_TARGET = 600;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 10;

   localparam int EP_FILL  = 0;
   localparam int EP_DRAIN = 1;
   localparam int EP_MIX   = 2;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     start     = 1'b0;
   logic                     req_func  = OP_ENQUEUE;
   logic signed [WORD_W-1:0] req_value = '0;
   logic                     busy;
   logic                     rsp_strobe;
   logic signed [WORD_W-1:0] rsp_data_out;
   logic [1:0]               rsp_status;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int beats_sent  = 0;

   two_stack_queue i_dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_data_out (rsp_data_out),
      .rsp_status   (rsp_status)
   );

   tsq_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_func     (req_func),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_data_out (rsp_data_out),
      .rsp_status   (rsp_status),
      .fail_count   (fail_count),
      .pending      (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic signed [WORD_W-1:0] random_word();
      case ($urandom_range(0, 9))
         0:       return EMPTY_WORD;
         1:       return ZERO_WORD;
         2:       return {1'b1, {(WORD_W-1){1'b0}}};
         3:       return {1'b0, {(WORD_W-1){1'b1}}};
         default: return $urandom;
      endcase
   endfunction

   function automatic int next_gap(input bit no_idle);
      return no_idle ? 0 : $urandom_range(0, 6);
   endfunction

   task automatic send_beat(input op_type op, input logic signed [WORD_W-1:0] word,
                            input int gap);
      start     <= 1'b1;
      req_func  <= op;
      req_value <= word;
      do @(posedge clock); while (busy);
      beats_sent++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic run_episode(input int kind, input int count, input bit no_idle);
      op_type op;
      repeat (count) begin
         case (kind)
            EP_FILL:  op = OP_ENQUEUE;
            EP_DRAIN: op = OP_DEQUEUE;
            default:  op = ($urandom_range(0, 1) == 0) ? OP_ENQUEUE : OP_DEQUEUE;
         endcase
         send_beat(op, random_word(), next_gap(no_idle));
      end
   endtask

   initial begin
      int  kind;
      int  count;
      bit  no_idle;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty queue, word extremes, refill order, dequeued -1
      send_beat(OP_DEQUEUE, 32'h1234_5678, next_gap(0));
      send_beat(OP_ENQUEUE, 32'h8000_0000, next_gap(0));
      send_beat(OP_ENQUEUE, 32'h7FFF_FFFF, next_gap(0));
      send_beat(OP_ENQUEUE, EMPTY_WORD, next_gap(0));
      send_beat(OP_ENQUEUE, ZERO_WORD, next_gap(0));
      send_beat(OP_ENQUEUE, 32'sd1, next_gap(0));
      send_beat(OP_DEQUEUE, 32'hFFFF_FFFF, next_gap(0));
      send_beat(OP_ENQUEUE, 32'h5555_5555, next_gap(0));
      send_beat(OP_DEQUEUE, ZERO_WORD, 0);
      send_beat(OP_DEQUEUE, ZERO_WORD, 0);
      send_beat(OP_DEQUEUE, ZERO_WORD, 0);
      send_beat(OP_DEQUEUE, ZERO_WORD, next_gap(0));
      send_beat(OP_DEQUEUE, ZERO_WORD, next_gap(0));
      send_beat(OP_DEQUEUE, 32'hAAAA_AAAA, next_gap(0));
      send_beat(OP_ENQUEUE, 32'hAAAA_AAAA, 0);
      send_beat(OP_DEQUEUE, 32'h5555_5555, 0);
      send_beat(OP_DEQUEUE, ZERO_WORD, next_gap(0));
      wait_drained();

      // fill past capacity for overflow, then drain past empty
      run_episode(EP_FILL, STACK_DEPTH + 7, 1'b0);
      run_episode(EP_DRAIN, STACK_DEPTH + 12, 1'b1);

      while (beats_sent < ITEM_TARGET) begin
         kind    = $urandom_range(EP_FILL, EP_MIX);
         count   = ($urandom_range(0, 3) == 0) ? $urandom_range(100, STACK_DEPTH + 12)
                                               : $urandom_range(1, 24);
         if (count > ITEM_TARGET - beats_sent) begin
            count = ITEM_TARGET - beats_sent;
         end
         no_idle = ($urandom_range(0, 3) == 0);
         run_episode(kind, count, no_idle);
         if ($urandom_range(0, 4) == 0) begin
            wait_drained();
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
